>>> sv/serial_decimal_command_parser_defines.svh
// ----------------------------------------------------------------------------
// Serial decimal command parser assertion macros
// Shared assertion forms for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef SERIAL_DECIMAL_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_DECIMAL_COMMAND_PARSER_DEFINES_SVH

// Checked only while reset is released.
`define SDCP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SDCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sdcp_pkg.sv
// ----------------------------------------------------------------------------
// sdcp_pkg
// Character codes, result codes, state bundle and fraction weights shared by
// the serial decimal command parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdcp_pkg;

	localparam int unsigned ACC_W   = 16;
	localparam int unsigned GAIN_W  = 33;
	localparam int unsigned SPEED_W = 15;
	localparam int unsigned FCNT_W  = 3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_V     = 8'h56;

	localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

	typedef enum logic [1:0] {
		TGT_PGAIN = 2'd0,
		TGT_DGAIN = 2'd1,
		TGT_SPEED = 2'd2,
		TGT_NONE  = 2'd3
	} target_t;

	// What the result formatter needs to see of the parser state.
	typedef struct packed {
		logic [7:0]       letter;
		logic             has_letter;
		logic             digit_seen;
		logic [ACC_W-1:0] int_acc;
		logic [ACC_W-1:0] frac_acc;
	} sdcp_state_t;

	// Q0.16 weight of the k-th digit after the point: round(65536 / 10^k).
	function automatic logic [12:0] frac_weight(input logic [FCNT_W-1:0] k);
		logic [12:0] w;
		case (k)
			3'd1:    w = 13'd6554;
			3'd2:    w = 13'd655;
			3'd3:    w = 13'd66;
			3'd4:    w = 13'd7;
			3'd5:    w = 13'd1;
			default: w = 13'd0;
		endcase
		return w;
	endfunction

endpackage

>>> sv/sdcp_accum.sv
// ----------------------------------------------------------------------------
// sdcp_accum
// Message state of the parser: command letter, byte count and the decimal
// integer and fraction accumulators, updated by one byte per cycle while take is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcp_accum
	import sdcp_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH        = 20,
	parameter int unsigned NUMBER_END_POSITION = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic        clear,
	input  logic [7:0]  rx_byte,
	output sdcp_state_t state
);

	localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);

	logic [PW-1:0]     pos_q;
	logic [7:0]        letter_q;
	logic              digit_seen_q;
	logic              in_frac_q;
	logic [ACC_W-1:0]  int_q;
	logic [ACC_W-1:0]  frac_q;
	logic [FCNT_W-1:0] fcnt_q;

	logic [PW-1:0]     pos_d;
	logic [7:0]        letter_d;
	logic              digit_seen_d;
	logic              in_frac_d;
	logic [ACC_W-1:0]  int_d;
	logic [ACC_W-1:0]  frac_d;
	logic [FCNT_W-1:0] fcnt_d;

	logic              is_digit;
	logic [3:0]        digit;
	logic              buf_full;
	logic              past_number;
	logic [FCNT_W-1:0] k_next;
	logic [19:0]       int_next;
	logic [16:0]       frac_next;

	assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	// The digit codes start at 0x30, so the value sits in the low nibble.
	assign digit       = rx_byte[3:0];
	assign buf_full    = 32'(pos_q) >= BUFFER_DEPTH;
	assign past_number = 32'(pos_q) >= NUMBER_END_POSITION;
	assign k_next      = (fcnt_q == {FCNT_W{1'b1}}) ? fcnt_q : fcnt_q + 1'b1;
	assign int_next    = ({4'd0, int_q} << 3) + ({4'd0, int_q} << 1) + 20'(digit);
	assign frac_next   = 17'(frac_q) + 17'(digit) * 17'(frac_weight(k_next));

	always_comb begin
		pos_d        = pos_q;
		letter_d     = letter_q;
		digit_seen_d = digit_seen_q;
		in_frac_d    = in_frac_q;
		int_d        = int_q;
		frac_d       = frac_q;
		fcnt_d       = fcnt_q;
		if (!buf_full) begin
			pos_d = pos_q + 1'b1;
			if (pos_q == '0) begin
				letter_d = rx_byte;
			end else if (!digit_seen_q) begin
				if (is_digit) begin
					digit_seen_d = 1'b1;
					int_d        = ACC_W'(digit);
				end
			end else if (!past_number) begin
				if (rx_byte == CH_POINT) begin
					in_frac_d = 1'b1;
					fcnt_d    = '0;
				end else if (is_digit) begin
					if (in_frac_q) begin
						fcnt_d = k_next;
						frac_d = frac_next[16] ? {ACC_W{1'b1}} : frac_next[ACC_W-1:0];
					end else begin
						int_d = (int_next[19:16] != 4'd0) ? {ACC_W{1'b1}} : int_next[ACC_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			letter_q     <= '0;
			digit_seen_q <= 1'b0;
			in_frac_q    <= 1'b0;
			int_q        <= '0;
			frac_q       <= '0;
			fcnt_q       <= '0;
		end else if (clear) begin
			pos_q        <= '0;
			letter_q     <= '0;
			digit_seen_q <= 1'b0;
			in_frac_q    <= 1'b0;
			int_q        <= '0;
			frac_q       <= '0;
			fcnt_q       <= '0;
		end else if (take) begin
			pos_q        <= pos_d;
			letter_q     <= letter_d;
			digit_seen_q <= digit_seen_d;
			in_frac_q    <= in_frac_d;
			int_q        <= int_d;
			frac_q       <= frac_d;
			fcnt_q       <= fcnt_d;
		end
	end

	assign state.letter     = letter_q;
	assign state.has_letter = (pos_q != '0);
	assign state.digit_seen = digit_seen_q;
	assign state.int_acc    = int_q;
	assign state.frac_acc   = frac_q;

endmodule

>>> sv/sdcp_format.sv
// ----------------------------------------------------------------------------
// sdcp_format
// Turns the finished message state into a command: target, negated Q16.16
// gain and saturated speed setpoint.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcp_format
	import sdcp_pkg::*;
(
	input  sdcp_state_t        state,
	output target_t            target,
	output logic [GAIN_W-1:0]  gain_value,
	output logic [SPEED_W-1:0] speed_value
);

	logic [GAIN_W-1:0] magnitude;

	assign magnitude = {1'b0, state.int_acc, state.frac_acc};

	always_comb begin
		if (!state.digit_seen || !state.has_letter) begin
			target = TGT_NONE;
		end else if (state.letter == CH_P) begin
			target = TGT_PGAIN;
		end else if (state.letter == CH_D) begin
			target = TGT_DGAIN;
		end else if (state.letter == CH_V) begin
			target = TGT_SPEED;
		end else begin
			target = TGT_NONE;
		end
	end

	always_comb begin
		gain_value  = '0;
		speed_value = '0;
		case (target)
			TGT_PGAIN, TGT_DGAIN: begin
				gain_value = '0 - magnitude;
			end
			TGT_SPEED: begin
				speed_value = state.int_acc[ACC_W-1] ? SPEED_MAX : state.int_acc[SPEED_W-1:0];
			end
			default: begin
				gain_value  = '0;
				speed_value = '0;
			end
		endcase
	end

endmodule

>>> sv/serial_decimal_command_parser.sv
// A '/' word waits in the input register until no command is waiting or the
// waiting one is being taken, then shows as a command on the master side.
// Throughput: one received word per cycle, except while a '/' waits for a
// busy result slot; the accumulator update is one add and compare stage
// between the input register and the state registers.
// Reset: arst_n clears all message state and both valid flags at once.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// serial_decimal_command_parser
// Parses '/'-terminated ASCII messages into gain and speed commands.
// ----------------------------------------------------------------------------
module serial_decimal_command_parser
	import sdcp_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH        = 20,
	parameter int unsigned NUMBER_END_POSITION = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [32:0] gain_value, [47:33] speed_value
	output logic [1:0]  m_axis_tuser    // [1:0] target
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               slash_s1;
	logic               out_free;
	logic               adv_s1;
	logic               take;
	logic               clear;
	sdcp_state_t        state;
	target_t            target;
	logic [GAIN_W-1:0]  gain_value;
	logic [SPEED_W-1:0] speed_value;

	logic               m_valid_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SPEED_W-1:0] speed_q;
	logic [1:0]         target_q;

	assign slash_s1 = (byte_s1 == CH_SLASH);
	assign out_free = !m_valid_q || m_axis_tready;
	// Ordinary bytes never wait; only a terminator needs the result slot.
	assign adv_s1   = valid_s1 && (!slash_s1 || out_free);
	assign take     = adv_s1 && !slash_s1;
	assign clear    = adv_s1 && slash_s1;

	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	sdcp_accum #(
		.BUFFER_DEPTH        (BUFFER_DEPTH),
		.NUMBER_END_POSITION (NUMBER_END_POSITION)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.clear   (clear),
		.rx_byte (byte_s1),
		.state   (state)
	);

	sdcp_format u_format (
		.state       (state),
		.target      (target),
		.gain_value  (gain_value),
		.speed_value (speed_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (clear) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			target_q <= target;
			gain_q   <= gain_value;
			speed_q  <= speed_value;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {speed_q, gain_q};
	assign m_axis_tuser  = target_q;

endmodule

>>> sv/sdcp_checker.sv
// ----------------------------------------------------------------------------
// sdcp_checker
// Port-level checks of the command stream, bound to the parser top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_decimal_command_parser_defines.svh"

module sdcp_checker
	import sdcp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// The valid flag is only known once the first edge under reset has passed.
	`SDCP_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_axis_tvalid, "command word valid during reset")

	`SDCP_ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled command word changed")

	// A gain command is never positive and carries no speed.
	`SDCP_ASSERT_CLK(a_gain_form, clk, arst_n, m_axis_tvalid && (m_axis_tuser == TGT_PGAIN || m_axis_tuser == TGT_DGAIN) |-> (m_axis_tdata[32] || m_axis_tdata[32:0] == 33'd0) && m_axis_tdata[47:33] == 15'd0, "malformed gain command")

	`SDCP_ASSERT_CLK(a_speed_form, clk, arst_n, m_axis_tvalid && m_axis_tuser == TGT_SPEED |-> m_axis_tdata[32:0] == 33'd0, "speed command carries a gain")

	`SDCP_ASSERT_CLK(a_none_form, clk, arst_n, m_axis_tvalid && m_axis_tuser == TGT_NONE |-> m_axis_tdata == 48'd0, "empty command carries data")

endmodule

bind serial_decimal_command_parser sdcp_checker u_sdcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_serial_decimal_command_parser.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_serial_decimal_command_parser
// Feeds ASCII words to the parser and checks every command it emits against a
// cycle-free software parser kept in the bench. Directed messages come first,
// then randomized well-formed messages mixed with noise and broken input.
// Both stream sides see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_serial_decimal_command_parser;
	import sdcp_pkg::*;

	localparam int unsigned MSG_DEPTH  = 20;
	localparam int unsigned NUM_LIMIT  = 10;
	localparam int unsigned WORD_GOAL  = 950;
	localparam int unsigned FRAC_LSB[8] = '{0, 6554, 655, 66, 7, 1, 0, 0};

	typedef struct packed {
		target_t            tgt;
		logic [GAIN_W-1:0]  gain;
		logic [SPEED_W-1:0] speed;
	} command_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	command_t    commands_due[$];
	int unsigned words_sent = 0;
	int unsigned calm_words = 0;
	int unsigned mismatch_count = 0;

	// Bench copy of the message state.
	logic [7:0]  msg_letter;
	int unsigned msg_pos;
	bit          msg_digit;
	bit          msg_in_frac;
	int unsigned msg_int;
	int unsigned msg_frac;
	int unsigned msg_frac_cnt;

	serial_decimal_command_parser #(
		.BUFFER_DEPTH       (MSG_DEPTH),
		.NUMBER_END_POSITION(NUM_LIMIT)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("tb_serial_decimal_command_parser: FAIL");
		$finish;
	end

	function void clear_message();
		msg_letter   = 8'h00;
		msg_pos      = 0;
		msg_digit    = 1'b0;
		msg_in_frac  = 1'b0;
		msg_int      = 0;
		msg_frac     = 0;
		msg_frac_cnt = 0;
	endfunction

	// Advances the bench parser by one accepted word and queues the command
	// that a '/' produces.
	function void parse_word(input logic [7:0] ch);
		command_t    cmd;
		logic [31:0] fixed;
		int unsigned pos;
		int unsigned d;
		bit          is_digit;
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		d = 32'(ch) - 32'(CH_ZERO);
		pos = msg_pos;
		if (ch == CH_SLASH) begin
			if (!msg_digit || msg_pos == 0) begin
				cmd.tgt = TGT_NONE;
			end else begin
				case (msg_letter)
					CH_P:    cmd.tgt = TGT_PGAIN;
					CH_D:    cmd.tgt = TGT_DGAIN;
					CH_V:    cmd.tgt = TGT_SPEED;
					default: cmd.tgt = TGT_NONE;
				endcase
			end
			fixed = {msg_int[15:0], msg_frac[15:0]};
			cmd.gain = '0;
			cmd.speed = '0;
			if (cmd.tgt == TGT_PGAIN || cmd.tgt == TGT_DGAIN)
				cmd.gain = 33'd0 - {1'b0, fixed};
			else if (cmd.tgt == TGT_SPEED)
				cmd.speed = (msg_int > 32767) ? SPEED_MAX : msg_int[SPEED_W-1:0];
			commands_due.push_back(cmd);
			clear_message();
			return;
		end
		if (pos >= MSG_DEPTH)
			return;
		msg_pos = pos + 1;
		if (pos == 0) begin
			msg_letter = ch;
			return;
		end
		if (!msg_digit) begin
			if (is_digit) begin
				msg_digit = 1'b1;
				msg_int = d;
			end
			return;
		end
		if (pos >= NUM_LIMIT)
			return;
		if (ch == CH_POINT) begin
			msg_in_frac = 1'b1;
			msg_frac_cnt = 0;
			return;
		end
		if (!is_digit)
			return;
		if (msg_in_frac) begin
			msg_frac_cnt = (msg_frac_cnt >= 7) ? 7 : msg_frac_cnt + 1;
			msg_frac = msg_frac + d * FRAC_LSB[msg_frac_cnt];
			if (msg_frac > 65535)
				msg_frac = 65535;
		end else begin
			msg_int = msg_int * 10 + d;
			if (msg_int > 65535)
				msg_int = 65535;
		end
	endfunction

	// Mostly back to back, sometimes a short gap, rarely a long pause.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input logic [7:0] ch);
		int unsigned gap;
		if (calm_words != 0) begin
			calm_words--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				calm_words = $urandom_range(20, 60);
			gap = pick_gap();
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		parse_word(ch);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_word(s[i]);
	endtask

	task automatic test_commands();
		send_text("P12.5/");
		send_text("D0.05/");
		send_text("V1234/");
		send_text("Q7/");
	endtask

	task automatic test_saturation();
		send_text("V32768/");
		send_text("V99999/");
		send_text("P99999.999/");
		send_text("D0.9999/");
		send_text("P1.9999999/");
	endtask

	task automatic test_malformed();
		// Empty message, letter with no digit, digit used as the letter.
		send_text("/");
		send_text("P/");
		send_text("5P3/");
		// Point before the first digit, strays inside, repeated points.
		send_text("D.x5/");
		send_text("Pa3b4/");
		send_text("P1.2.3.9/");
		send_word(8'hFF);
		send_word(8'h00);
		send_text("/");
	endtask

	task automatic test_overflow();
		// Digits run past the number end and bytes past the message depth.
		send_text("V123456789012345678901234/");
		send_text("Pxxxxxxxxxxxxxxxxxxxxxx7/");
	endtask

	task automatic send_noise_byte();
		logic [7:0] ch;
		do ch = 8'($urandom_range(0, 255)); while (ch == CH_SLASH);
		send_word(ch);
	endtask

	task automatic send_digits(input int unsigned n);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				send_word(CH_NINE);
			else
				send_word(8'(CH_ZERO + $urandom_range(0, 9)));
		end
	endtask

	task automatic send_random_message();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// Raw noise, which may hold a '/' of its own.
			repeat ($urandom_range(1, 12)) send_word(8'($urandom_range(0, 255)));
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 30)
			send_word(CH_P);
		else if (r < 55)
			send_word(CH_D);
		else if (r < 85)
			send_word(CH_V);
		else if (r < 97)
			send_noise_byte();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 2) == 0)
					send_word(CH_POINT);
				else
					send_word(8'("a" + $urandom_range(0, 25)));
			end
		end
		send_digits($urandom_range(0, 6));
		if ($urandom_range(0, 9) == 0)
			send_noise_byte();
		if ($urandom_range(0, 1) == 0) begin
			send_word(CH_POINT);
			send_digits($urandom_range(0, 8));
			if ($urandom_range(0, 9) == 0) begin
				send_word(CH_POINT);
				send_digits($urandom_range(1, 4));
			end
		end
		if ($urandom_range(0, 19) == 0)
			repeat ($urandom_range(10, 20)) send_noise_byte();
		send_word(CH_SLASH);
	endtask

	task automatic test_random_messages();
		while (words_sent < WORD_GOAL)
			send_random_message();
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin : check_commands
		command_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (commands_due.size() == 0) begin
				note_mismatch($sformatf("unexpected command target=%0d tdata=%h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = commands_due.pop_front();
				if (m_axis_tuser !== want.tgt || m_axis_tdata[32:0] !== want.gain
						|| m_axis_tdata[47:33] !== want.speed) begin
					note_mismatch($sformatf(
						"expected target=%0d gain=%h speed=%0d, got target=%0d gain=%h speed=%0d",
						want.tgt, want.gain, want.speed,
						m_axis_tuser, m_axis_tdata[32:0], m_axis_tdata[47:33]));
				end
			end
		end
	end

	initial begin : sink_pacing
		int unsigned run_len;
		int unsigned stall_len;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0)
				run_len = $urandom_range(40, 120);
			else
				run_len = $urandom_range(1, 8);
			m_axis_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin
		clear_message();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_saturation();
		test_malformed();
		test_overflow();
		test_random_messages();
		s_axis_tvalid <= 1'b0;
		while (commands_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_serial_decimal_command_parser: PASS");
		else
			$display("tb_serial_decimal_command_parser: FAIL");
		$finish;
	end

endmodule
